>>> sv/chkv_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chained hash table package
// Shared widths, operation and status codes.
// ---------------------------------------------------------------------------
package chkv_pkg;
    localparam int BUCKET_COUNT = 16;
    localparam int NODE_COUNT   = 64;
    localparam int BW = $clog2(BUCKET_COUNT);
    localparam int NW = $clog2(NODE_COUNT + 1);
    localparam int IW = $clog2(NODE_COUNT);

    typedef logic [NW-1:0] t_link;
    localparam t_link NULL_LINK = t_link'(NODE_COUNT);

    typedef enum logic [1:0] {
        FUNC_PUT    = 2'd0,
        FUNC_GET    = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FULL     = 2'd2,
        ST_RSVD     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] result_value;
    } t_rsp;
endpackage

>>> sv/chkv_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Valid/ready channel
// One transaction moves when valid and ready are both high.
// ---------------------------------------------------------------------------
interface chkv_req_if;
    logic valid;
    logic ready;
    chkv_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface chkv_rsp_if;
    logic valid;
    logic ready;
    chkv_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> sv/chained_hash_key_value_table_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chained hash key-value table
// Put, get and remove on bucket chains drawn from a fixed node pool.
// ---------------------------------------------------------------------------
// Channel   Direction  Payload
// i_req     in         func, key, value
// o_rsp     out        status, result_value
//
// Put passes S_READ, plus S_CHECK when it reuses a node from the free list.
// Get and remove pass S_READ and S_CHECK per node visited, plus S_READ once
// more on a miss; the single read port of the node memory sets the walk rate.
// Link update on remove adds S_FREE, after S_UNLINK if the match is not the head.
// Reset clears bucket heads (flip-flops), the free list and the fresh count.
// One item is worked at a time; a held result blocks the next item only.
module chained_hash_key_value_table_top (
    input  logic i_clk,
    input  logic i_rst_n,
    chkv_req_if.sink   i_req,
    chkv_rsp_if.source o_rsp
);
    localparam int NW = chkv_pkg::NW;
    localparam int IW = chkv_pkg::IW;
    localparam int BW = chkv_pkg::BW;
    localparam int CW = $clog2(chkv_pkg::NODE_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_CHECK, S_UNLINK, S_FREE, S_OUT
    } t_state;

    t_state r_state;
    chkv_pkg::t_link r_heads [chkv_pkg::BUCKET_COUNT];
    chkv_pkg::t_link r_free, r_cur, r_prev;
    logic [CW-1:0] r_fresh, r_steps;
    logic [1:0]  r_func;
    logic [31:0] r_key, r_val;
    logic [31:0] r_pkey, r_pval;
    logic [BW-1:0] r_bkt;
    logic [NW-1:0] r_next;
    logic [1:0]  r_status;
    logic [31:0] r_rval;

    // Node memory port signals.
    logic                we;
    logic [IW-1:0]       waddr, raddr;
    logic [64+NW-1:0]    wdata, rdata;
    logic [31:0]         rd_key, rd_val;
    chkv_pkg::t_link     rd_link;

    assign rd_key  = rdata[64+NW-1:32+NW];
    assign rd_val  = rdata[32+NW-1:NW];
    assign rd_link = rdata[NW-1:0];

    chkv_node_mem u_mem (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = (r_state == S_OUT);
    assign o_rsp.data.status       = r_status;
    assign o_rsp.data.result_value = r_rval;

    // Memory requests per state.
    always_comb begin
        we    = 1'b0;
        waddr = r_cur[IW-1:0];
        wdata = {r_key, r_val, r_heads[r_bkt]};
        raddr = r_cur[IW-1:0];
        unique case (r_state)
            S_READ: begin
                if (r_func == chkv_pkg::FUNC_PUT) begin
                    we = (r_cur != chkv_pkg::NULL_LINK);
                end
            end
            S_UNLINK: begin
                // Rewrite previous node with the link of the match.
                we    = 1'b1;
                waddr = r_prev[IW-1:0];
                wdata = {r_pkey, r_pval, r_next};
            end
            S_FREE: begin
                we    = 1'b1;
                waddr = r_cur[IW-1:0];
                wdata = {r_key, r_rval, r_free};
            end
            default: ;
        endcase
    end

    // Control sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_free  <= chkv_pkg::NULL_LINK;
            r_fresh <= '0;
            for (int i = 0; i < chkv_pkg::BUCKET_COUNT; i++) begin
                r_heads[i] <= chkv_pkg::NULL_LINK;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_func  <= i_req.data.func;
                        r_key   <= i_req.data.key;
                        r_val   <= i_req.data.value;
                        r_bkt   <= i_req.data.key[BW-1:0];
                        r_prev  <= chkv_pkg::NULL_LINK;
                        r_steps <= '0;
                        r_rval  <= '0;
                        r_status <= chkv_pkg::ST_NOTFOUND;
                        if (i_req.data.func == chkv_pkg::FUNC_PUT) begin
                            // Pick a node: free list first, then fresh pool.
                            if (r_free != chkv_pkg::NULL_LINK) begin
                                r_cur <= r_free;
                            end else if (r_fresh < CW'(chkv_pkg::NODE_COUNT)) begin
                                r_cur <= NW'(r_fresh);
                            end else begin
                                r_cur <= chkv_pkg::NULL_LINK;
                            end
                            r_state <= S_READ;
                        end else if (i_req.data.func == chkv_pkg::FUNC_NONE) begin
                            r_state <= S_OUT;
                        end else begin
                            r_cur   <= r_heads[i_req.data.key[BW-1:0]];
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    if (r_func == chkv_pkg::FUNC_PUT) begin
                        if (r_cur == chkv_pkg::NULL_LINK) begin
                            r_status <= chkv_pkg::ST_FULL;
                            r_state  <= S_OUT;
                        end else if (r_cur == r_free) begin
                            // Need the old link of the free node: read issued now.
                            r_state <= S_CHECK;
                        end else begin
                            r_fresh <= r_fresh + 1'b1;
                            r_heads[r_bkt] <= r_cur;
                            r_status <= chkv_pkg::ST_OK;
                            r_state  <= S_OUT;
                        end
                    end else if (r_cur == chkv_pkg::NULL_LINK
                                 || r_steps == CW'(chkv_pkg::NODE_COUNT)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_func == chkv_pkg::FUNC_PUT) begin
                        // Read data is the free node before the write took effect.
                        r_free <= rd_link;
                        r_heads[r_bkt] <= r_cur;
                        r_status <= chkv_pkg::ST_OK;
                        r_state  <= S_OUT;
                    end else if (rd_key == r_key) begin
                        r_status <= chkv_pkg::ST_OK;
                        r_rval   <= rd_val;
                        r_next   <= rd_link;
                        if (r_func == chkv_pkg::FUNC_GET) begin
                            r_state <= S_OUT;
                        end else if (r_prev == chkv_pkg::NULL_LINK) begin
                            r_heads[r_bkt] <= rd_link;
                            r_state <= S_FREE;
                        end else begin
                            r_key   <= rd_key;
                            r_state <= S_UNLINK;
                        end
                    end else begin
                        // Keep the visited node's contents for a later unlink.
                        r_pkey  <= rd_key;
                        r_pval  <= rd_val;
                        r_prev  <= r_cur;
                        r_cur   <= rd_link;
                        r_steps <= r_steps + 1'b1;
                        r_state <= S_READ;
                    end
                end
                S_UNLINK: begin
                    // Previous node keeps the key and value captured during the walk.
                    r_state <= S_FREE;
                end
                S_FREE: begin
                    r_free  <= r_cur;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

>>> sv/chkv_node_mem.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Node memory
// Node key, value and link in one word; one write and one registered read.
// ---------------------------------------------------------------------------
module chkv_node_mem (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [chkv_pkg::IW-1:0]    i_waddr,
    input  logic [64+chkv_pkg::NW-1:0] i_wdata,
    input  logic [chkv_pkg::IW-1:0]    i_raddr,
    output logic [64+chkv_pkg::NW-1:0] o_rdata
);
    logic [64+chkv_pkg::NW-1:0] r_mem [chkv_pkg::NODE_COUNT];

    // Synchronous write and read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> dv/chained_hash_key_value_table_top_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Chained hash key-value table testbench
// Drives put, get and remove transactions through the request channel,
// predicts every response with a local model of the bucket chains and node
// pool, and compares each response field by field under varied idling.
// ---------------------------------------------------------------------------
module chained_hash_key_value_table_top_tb;
    typedef struct {
        logic [1:0]  status;
        logic [31:0] result_value;
    } t_expect;

    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk;
    logic i_rst_n;

    chkv_req_if req_ch();
    chkv_rsp_if rsp_ch();

    chained_hash_key_value_table_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Table state mirrored by the predictor.
    chkv_pkg::t_link heads[chkv_pkg::BUCKET_COUNT];
    logic [31:0]     nkeys[chkv_pkg::NODE_COUNT];
    logic [31:0]     nvals[chkv_pkg::NODE_COUNT];
    chkv_pkg::t_link nlinks[chkv_pkg::NODE_COUNT];
    chkv_pkg::t_link free_head;
    int              fresh_used;

    // Keys that are live in the table, for well-formed random traffic.
    logic [31:0] live_keys[$];

    t_expect pending_rsp[$];
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      hold_off;
    bit      failed;
    int      cycle_cnt;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // Runaway guard.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Work out the response of one request and update the mirrored table.
    function automatic t_expect predict_table_op(chkv_pkg::t_func op, logic [31:0] k,
                                                 logic [31:0] v);
        t_expect         r;
        chkv_pkg::t_link n;
        chkv_pkg::t_link cur;
        chkv_pkg::t_link prev;
        int              b;
        int              steps;
        r.status = chkv_pkg::ST_NOTFOUND;
        r.result_value = '0;
        b = int'(k[chkv_pkg::BW-1:0]);
        case (op)
            chkv_pkg::FUNC_PUT: begin
                if (free_head < chkv_pkg::NULL_LINK) begin
                    n = free_head;
                    free_head = nlinks[n];
                end else if (fresh_used < chkv_pkg::NODE_COUNT) begin
                    n = chkv_pkg::t_link'(fresh_used);
                    fresh_used++;
                end else begin
                    r.status = chkv_pkg::ST_FULL;
                    return r;
                end
                nkeys[n] = k;
                nvals[n] = v;
                nlinks[n] = heads[b];
                heads[b] = n;
                r.status = chkv_pkg::ST_OK;
            end
            chkv_pkg::FUNC_GET, chkv_pkg::FUNC_REMOVE: begin
                prev = chkv_pkg::NULL_LINK;
                cur = heads[b];
                steps = 0;
                while (cur < chkv_pkg::NULL_LINK && steps < chkv_pkg::NODE_COUNT) begin
                    if (nkeys[cur] == k) begin
                        r.status = chkv_pkg::ST_OK;
                        r.result_value = nvals[cur];
                        if (op == chkv_pkg::FUNC_REMOVE) begin
                            if (prev < chkv_pkg::NULL_LINK) nlinks[prev] = nlinks[cur];
                            else heads[b] = nlinks[cur];
                            nlinks[cur] = free_head;
                            free_head = cur;
                        end
                        return r;
                    end
                    prev = cur;
                    cur = nlinks[cur];
                    steps++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Send one request transaction, with random idle cycles first.
    // Valid stays high after the handshake until the next idle cycle or drain.
    task automatic send_request(chkv_pkg::t_func op, logic [31:0] k, logic [31:0] v);
        int idx;
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= '{func: op, key: k, value: v};
        do @(posedge i_clk); while (!req_ch.ready);
        pending_rsp.push_back(predict_table_op(op, k, v));
        // Keep the list of live keys roughly in step with the table.
        if (op == chkv_pkg::FUNC_PUT && pending_rsp[$].status == chkv_pkg::ST_OK)
            live_keys.push_back(k);
        if (op == chkv_pkg::FUNC_REMOVE && pending_rsp[$].status == chkv_pkg::ST_OK) begin
            idx = -1;
            foreach (live_keys[i]) if (live_keys[i] == k && idx < 0) idx = i;
            if (idx >= 0) live_keys.delete(idx);
        end
    endtask

    // Response ready with random stalls, or held low during a hold-off.
    always @(posedge i_clk) begin
        if (!i_rst_n) rsp_ch.ready <= 1'b0;
        else rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Compare every response transaction with the oldest expectation.
    always @(posedge i_clk) begin
        t_expect e;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("unexpected response: status %0d value %h",
                       rsp_ch.data.status, rsp_ch.data.result_value);
                failed = 1'b1;
            end else begin
                e = pending_rsp.pop_front();
                if (rsp_ch.data.status !== e.status) begin
                    $error("status: expected %0d, actual %0d", e.status, rsp_ch.data.status);
                    failed = 1'b1;
                end
                if (rsp_ch.data.result_value !== e.result_value) begin
                    $error("result_value: expected %h, actual %h",
                           e.result_value, rsp_ch.data.result_value);
                    failed = 1'b1;
                end
            end
        end
    end

    // Stop offering requests and wait for every expected response.
    task automatic wait_drained();
        req_ch.valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    // A key with a chosen bucket and random upper bits.
    function automatic logic [31:0] key_in_bucket(int b);
        logic [31:0] k;
        k = $urandom();
        k[chkv_pkg::BW-1:0] = b[chkv_pkg::BW-1:0];
        return k;
    endfunction

    // Extremes, every operation, misses, shadowing, chain unlinking.
    task automatic test_directed();
        send_request(chkv_pkg::FUNC_GET, 32'h0, 32'h0);
        send_request(chkv_pkg::FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_request(chkv_pkg::FUNC_PUT, 32'h0, 32'hFFFF_FFFF);
        send_request(chkv_pkg::FUNC_PUT, 32'hFFFF_FFFF, 32'h0);
        send_request(chkv_pkg::FUNC_PUT, 32'h0, 32'h1234_5678);
        send_request(chkv_pkg::FUNC_GET, 32'h0, 32'hFFFF_FFFF);
        send_request(chkv_pkg::FUNC_GET, 32'hFFFF_FFFF, 32'h0);
        send_request(chkv_pkg::FUNC_NONE, 32'h0, 32'hFFFF_FFFF);
        send_request(chkv_pkg::FUNC_PUT, 32'h10, 32'hAAAA_5555);
        send_request(chkv_pkg::FUNC_PUT, 32'h20, 32'h5555_AAAA);
        send_request(chkv_pkg::FUNC_REMOVE, 32'h10, 32'h0);
        send_request(chkv_pkg::FUNC_REMOVE, 32'h0, 32'h0);
        send_request(chkv_pkg::FUNC_GET, 32'h0, 32'h0);
        send_request(chkv_pkg::FUNC_REMOVE, 32'h0, 32'h0);
        send_request(chkv_pkg::FUNC_GET, 32'h0, 32'h0);
        send_request(chkv_pkg::FUNC_GET, 32'h20, 32'h0);
        send_request(chkv_pkg::FUNC_REMOVE, 32'h30, 32'h0);
        wait_drained();
    endtask

    // Fill the pool past capacity, then empty it again.
    task automatic test_pool_full();
        logic [31:0] k;
        for (int i = 0; i < chkv_pkg::NODE_COUNT + 3; i++)
            send_request(chkv_pkg::FUNC_PUT, key_in_bucket(i % 3), $urandom());
        while (live_keys.size() != 0) begin
            k = live_keys[$urandom_range(live_keys.size() - 1)];
            send_request(chkv_pkg::FUNC_REMOVE, k, $urandom());
        end
        send_request(chkv_pkg::FUNC_PUT, 32'hFFFF_FFF0, 32'hDEAD_BEEF);
        send_request(chkv_pkg::FUNC_GET, 32'hFFFF_FFF0, 32'h0);
        wait_drained();
    endtask

    // Mostly operations on live keys in few buckets so chains grow long.
    task automatic test_random(int count);
        chkv_pkg::t_func op;
        logic [31:0]     k;
        int              pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 40 || live_keys.size() == 0) begin
                op = chkv_pkg::FUNC_PUT;
                k = (pick < 10 && live_keys.size() != 0)
                    ? live_keys[$urandom_range(live_keys.size() - 1)]
                    : key_in_bucket($urandom_range(3));
            end else begin
                op = (pick < 70) ? chkv_pkg::FUNC_GET : chkv_pkg::FUNC_REMOVE;
                k = (pick % 6 == 0)
                    ? key_in_bucket($urandom_range(chkv_pkg::BUCKET_COUNT - 1))
                    : live_keys[$urandom_range(live_keys.size() - 1)];
            end
            if (pick == 99) op = chkv_pkg::FUNC_NONE;
            send_request(op, k, $urandom());
        end
    endtask

    // Receiver holds off while requests keep coming, then the sender pauses.
    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            repeat (300) @(posedge i_clk);
            test_random(20);
        join_any
        hold_off = 1'b0;
        wait fork;
        wait_drained();
        test_random(20);
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    initial begin
        foreach (heads[i]) heads[i] = chkv_pkg::NULL_LINK;
        foreach (nlinks[i]) nlinks[i] = chkv_pkg::NULL_LINK;
        free_head = chkv_pkg::NULL_LINK;
        fresh_used = 0;
        failed = 1'b0;
        hold_off = 1'b0;
        cycle_cnt = 0;
        set_idling(0, 0);
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_pool_full();
        test_random(200);
        set_idling(47, 0);
        test_random(180);
        set_idling(0, 47);
        test_random(180);
        set_idling(19, 19);
        test_random(150);
        set_idling(0, 0);
        test_backpressure();

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (!failed && pending_rsp.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule
